// ----- hw/rtl/assert_macros.svh -----
// concurrent assertion helpers, clocked on the rising edge, muted during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ssc_pkg.sv -----
package ssc_pkg;

    localparam int SLOT_COUNT_DEF = 10;
    localparam int ID_WORDS_DEF   = 4;
    localparam int STAMP_BITS_DEF = 32;
    localparam int WORD_BITS      = 64;
    localparam int ID_MAX_WORDS   = 4;
    localparam int ID_MAX_BITS    = ID_MAX_WORDS * WORD_BITS;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_END   = 2'd1,
        MODE_CLEAR = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_PEEK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]           mode;
        logic                 has_id;
        logic [WORD_BITS-1:0] want_id_w0;
        logic [WORD_BITS-1:0] want_id_w1;
        logic [WORD_BITS-1:0] want_id_w2;
        logic [WORD_BITS-1:0] want_id_w3;
        logic [WORD_BITS-1:0] fresh_id_w0;
        logic [WORD_BITS-1:0] fresh_id_w1;
        logic [WORD_BITS-1:0] fresh_id_w2;
        logic [WORD_BITS-1:0] fresh_id_w3;
    } t_ssc_req;

    typedef struct packed {
        logic [3:0]           slot_index;
        logic                 reused;
        logic                 active_valid;
        logic [WORD_BITS-1:0] out_id_w0;
        logic [WORD_BITS-1:0] out_id_w1;
        logic [WORD_BITS-1:0] out_id_w2;
        logic [WORD_BITS-1:0] out_id_w3;
    } t_ssc_rsp;

endpackage

// ----- hw/rtl/ssc_req_if.sv -----
interface ssc_req_if import ssc_pkg::*;;
    logic     valid;
    logic     ready;
    t_ssc_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/ssc_rsp_if.sv -----
interface ssc_rsp_if import ssc_pkg::*;;
    logic     valid;
    logic     ready;
    t_ssc_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/session_slot_cache_lru.sv -----
// channel   dir  handshake      payload
// i_req     in   valid/ready    mode, has_id, want_id_w0..w3, fresh_id_w0..w3
// o_rsp     out  valid/ready    slot_index, reused, active_valid, out_id_w0..w3
//
// start reads the slot table one slot per cycle, then writes back
// end and clear go straight to done, the unused mode value first reads the active slot
// one item in flight; the next is taken once the result sits in the output register
// a stalled o_rsp holds the result and blocks only the finish of the next item
// reset empties every slot at once through per-slot valid flops, no clearing pass
module session_slot_cache_lru import ssc_pkg::*; #(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int ID_WORDS   = ID_WORDS_DEF,
    parameter int STAMP_BITS = STAMP_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ssc_req_if.sink   i_req,
    ssc_rsp_if.source o_rsp
);

    localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam int ID_W   = ID_WORDS * WORD_BITS;
    localparam int ENT_W  = STAMP_BITS + ID_W;

    t_state r_state, n_state;

    logic [ENT_W-1:0] mem [SLOT_COUNT];

    logic                  r_has_id;
    logic [ID_W-1:0]       r_want;
    logic [ID_W-1:0]       r_fresh;
    logic [SLOT_COUNT-1:0] r_valid;
    logic [STAMP_BITS-1:0] r_use;
    logic [IDX_W-1:0]      r_act_slot;
    logic                  r_act_flag;

    logic [CNT_W-1:0]      r_scan;
    logic                  r_rd_vld;
    logic [IDX_W-1:0]      r_rd_idx;
    logic [ENT_W-1:0]      r_rd_data;

    logic                  r_hit;
    logic [IDX_W-1:0]      r_hit_idx;
    logic                  r_emp;
    logic [IDX_W-1:0]      r_emp_idx;
    logic [STAMP_BITS-1:0] r_min_stamp;
    logic [IDX_W-1:0]      r_min_idx;

    t_ssc_rsp r_res;
    t_ssc_rsp r_out;
    logic     r_out_vld;

    logic                  in_acc;
    logic                  out_free;
    logic                  issue;
    logic                  load_out;
    logic                  mem_we;
    logic [IDX_W-1:0]      rd_addr;
    logic [STAMP_BITS-1:0] eff_stamp;
    logic [ID_W-1:0]       eff_id;
    logic                  live;
    logic                  id_eq;
    logic [IDX_W-1:0]      sel;
    logic [IDX_W+3:0]      sel_ext;
    logic [STAMP_BITS-1:0] new_stamp;
    logic [ID_W-1:0]       wr_id;
    logic [ID_MAX_BITS-1:0] want_full;
    logic [ID_MAX_BITS-1:0] fresh_full;
    logic [ID_MAX_BITS-1:0] wr_id_full;
    logic [ID_MAX_BITS-1:0] peek_id_full;

    assign in_acc   = i_req.valid && i_req.ready;
    assign out_free = !r_out_vld || o_rsp.ready;
    assign issue    = (r_state == S_SCAN) && (r_scan < CNT_W'(SLOT_COUNT));
    assign rd_addr  = issue ? r_scan[IDX_W-1:0] : r_act_slot;
    assign mem_we   = (r_state == S_WRITE);
    assign load_out = (r_state == S_DONE) && out_free;

    assign want_full  = {i_req.data.want_id_w3, i_req.data.want_id_w2,
                         i_req.data.want_id_w1, i_req.data.want_id_w0};
    assign fresh_full = {i_req.data.fresh_id_w3, i_req.data.fresh_id_w2,
                         i_req.data.fresh_id_w1, i_req.data.fresh_id_w0};

    // compare stage on the registered read data, an invalid slot reads as empty
    assign eff_stamp = r_valid[r_rd_idx] ? r_rd_data[ENT_W-1 -: STAMP_BITS] : '0;
    assign eff_id    = r_valid[r_rd_idx] ? r_rd_data[ID_W-1:0] : '0;
    assign live      = (eff_stamp != '0);
    assign id_eq     = (eff_id == r_want);

    // match, else first empty, else least recently used
    assign sel       = r_hit ? r_hit_idx : (r_emp ? r_emp_idx : r_min_idx);
    assign sel_ext   = {4'b0, sel};
    assign new_stamp = r_use + STAMP_BITS'(1);
    assign wr_id     = r_hit ? r_want : r_fresh;

    always_comb begin
        wr_id_full             = '0;
        wr_id_full[ID_W-1:0]   = wr_id;
        peek_id_full           = '0;
        if (r_act_flag) begin
            peek_id_full[ID_W-1:0] = r_rd_data[ID_W-1:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        i_req.ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    case (i_req.data.mode)
                        MODE_START:            n_state = S_SCAN;
                        MODE_END, MODE_CLEAR:  n_state = S_DONE;
                        default:               n_state = S_PEEK;
                    endcase
                end
            end
            S_SCAN: begin
                if (!issue && !r_rd_vld) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: n_state = S_DONE;
            S_PEEK:  n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[sel] <= {new_stamp, wr_id};
        end
        r_rd_data <= mem[rd_addr];
        r_rd_idx  <= rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= '0;
            r_use      <= '0;
            r_act_slot <= '0;
            r_act_flag <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_scan     <= '0;
            r_hit      <= 1'b0;
            r_emp      <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= issue;

            if (load_out) begin
                r_out     <= r_res;
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_has_id    <= i_req.data.has_id;
                        r_want      <= want_full[ID_W-1:0];
                        r_fresh     <= fresh_full[ID_W-1:0];
                        r_scan      <= '0;
                        r_hit       <= 1'b0;
                        r_emp       <= 1'b0;
                        r_min_stamp <= '1;
                        r_min_idx   <= '0;
                        r_res       <= '0;
                        case (i_req.data.mode)
                            MODE_END: begin
                                if (r_act_flag) begin
                                    r_valid[r_act_slot] <= 1'b0;
                                end
                                r_act_flag <= 1'b0;
                            end
                            MODE_CLEAR: begin
                                r_valid    <= '0;
                                r_act_flag <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (issue) begin
                        r_scan <= r_scan + CNT_W'(1);
                    end
                    if (r_rd_vld) begin
                        if (r_has_id && live && id_eq && !r_hit) begin
                            r_hit     <= 1'b1;
                            r_hit_idx <= r_rd_idx;
                        end
                        if (!live && !r_emp) begin
                            r_emp     <= 1'b1;
                            r_emp_idx <= r_rd_idx;
                        end
                        if (eff_stamp <= r_min_stamp) begin
                            r_min_stamp <= eff_stamp;
                            r_min_idx   <= r_rd_idx;
                        end
                    end
                end
                S_WRITE: begin
                    r_valid[sel]       <= 1'b1;
                    r_use              <= new_stamp;
                    r_act_slot         <= sel;
                    r_act_flag         <= 1'b1;
                    r_res.slot_index   <= sel_ext[3:0];
                    r_res.reused       <= r_hit;
                    r_res.active_valid <= 1'b1;
                    r_res.out_id_w0    <= wr_id_full[0*WORD_BITS +: WORD_BITS];
                    r_res.out_id_w1    <= wr_id_full[1*WORD_BITS +: WORD_BITS];
                    r_res.out_id_w2    <= wr_id_full[2*WORD_BITS +: WORD_BITS];
                    r_res.out_id_w3    <= wr_id_full[3*WORD_BITS +: WORD_BITS];
                end
                S_PEEK: begin
                    r_res.active_valid <= r_act_flag;
                    r_res.out_id_w0    <= peek_id_full[0*WORD_BITS +: WORD_BITS];
                    r_res.out_id_w1    <= peek_id_full[1*WORD_BITS +: WORD_BITS];
                    r_res.out_id_w2    <= peek_id_full[2*WORD_BITS +: WORD_BITS];
                    r_res.out_id_w3    <= peek_id_full[3*WORD_BITS +: WORD_BITS];
                end
                S_DONE: ;
                default: ;
            endcase
        end
    end

    assign o_rsp.valid = r_out_vld;
    assign o_rsp.data  = r_out;

endmodule

// ----- hw/rtl/ssc_checker.sv -----
`include "assert_macros.svh"

module ssc_checker import ssc_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_rsp_valid,
    input logic     i_rsp_ready,
    input t_ssc_rsp i_rsp_data
);

    `ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_data), "result changed while stalled")
    `ASSERT_IMPLY(a_idle_id_zero, i_clk, i_rst_n, i_rsp_valid && !i_rsp_data.active_valid, i_rsp_data.out_id_w0 == '0 && i_rsp_data.out_id_w1 == '0 && i_rsp_data.out_id_w2 == '0 && i_rsp_data.out_id_w3 == '0, "identifier shown with no active slot")
    `ASSERT_IMPLY(a_reuse_active, i_clk, i_rst_n, i_rsp_valid && i_rsp_data.reused, i_rsp_data.active_valid, "reuse without an active slot")
    `ASSERT_IMPLY(a_index_active, i_clk, i_rst_n, i_rsp_valid && i_rsp_data.slot_index != 4'd0, i_rsp_data.active_valid, "slot index without an active slot")

endmodule

bind session_slot_cache_lru ssc_checker u_ssc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);
